@@ rtl/core/periodic_timer_bank_defines.svh @@
// assertion macros shared by the timer bank
`ifndef PERIODIC_TIMER_BANK_DEFINES_SVH
`define PERIODIC_TIMER_BANK_DEFINES_SVH

// same-cycle implication, checked on every rising edge outside reset
`define PTB_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define PTB_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/core/ptb_pkg.sv @@
// types and constants of the periodic timer bank
package ptb_pkg;

   localparam int MAX_TIMERS         = 4;
   localparam int NUM_TIMERS_DEFAULT = 4;
   localparam int TICK_W             = 32;
   localparam int COUNT_W            = 3;
   localparam int MASK_W             = 4;
   localparam int INDEX_W            = 2;
   localparam int CSR_INDEX_W        = 3;
   localparam int CSR_DATA_W         = 32;
   localparam int REQ_DATA_W         = 8;
   localparam int REQ_USER_W         = 2;
   localparam int RSP_DATA_W         = 8;

   typedef enum logic [1:0] {
      MODE_TICK     = 2'd0,
      MODE_ACTIVATE = 2'd1,
      MODE_START    = 2'd2,
      MODE_STOP     = 2'd3
   } ptb_mode_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_TIMER_COUNT   = 3'd0,
      CSR_ONE_SHOT_MASK = 3'd1,
      CSR_PERIOD_0      = 3'd2,
      CSR_PERIOD_1      = 3'd3,
      CSR_PERIOD_2      = 3'd4,
      CSR_PERIOD_3      = 3'd5
   } ptb_csr_type;

   // per-cell control from the bank controller
   typedef struct packed {
      logic advance;    // chain may move this cycle
      logic clear;      // start: drop pending and armed
      logic activate;   // mark this timer pending
      logic period_we;  // load the period register
   } ptb_cell_ctrl_type;

endpackage

@@ rtl/core/ptb_cell.sv @@
// one timer cell: flags, trigger and period, visited when the scan token arrives
module ptb_cell (
   input  logic                        clock,
   input  logic                        reset,
   input  ptb_pkg::ptb_cell_ctrl_type  ctrl,
   input  logic                        token_in,
   input  logic                        active,
   input  logic                        one_shot,
   input  logic [ptb_pkg::TICK_W-1:0]  tick_count,
   input  logic [ptb_pkg::TICK_W-1:0]  period_wdata,
   output logic                        token_out,
   output logic                        expired
);
   import ptb_pkg::*;

   logic              token_ff;
   logic              pending_ff;
   logic              armed_ff;
   logic [TICK_W-1:0] trigger_ff;
   logic [TICK_W-1:0] period_ff;
   logic              visit;
   logic              pending_mid;
   logic              armed_mid;

   assign visit     = token_ff && ctrl.advance && active;
   assign expired   = visit && armed_ff && (tick_count >= trigger_ff);
   assign token_out = token_ff;

   // flags after the expiry step, before re-arming
   always_comb begin
      armed_mid   = armed_ff;
      pending_mid = pending_ff;
      if (expired) begin
         armed_mid   = 1'b0;
         pending_mid = !one_shot;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         token_ff   <= 1'b0;
         pending_ff <= 1'b0;
         armed_ff   <= 1'b0;
      end else begin
         if (ctrl.advance) begin
            token_ff <= token_in;
         end
         if (ctrl.clear) begin
            pending_ff <= 1'b0;
            armed_ff   <= 1'b0;
         end else if (ctrl.activate) begin
            pending_ff <= 1'b1;
         end else if (visit) begin
            if (pending_mid) begin
               armed_ff   <= 1'b1;
               pending_ff <= 1'b0;
            end else begin
               armed_ff   <= armed_mid;
               pending_ff <= pending_mid;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= '0;
      end else if (ctrl.period_we) begin
         period_ff <= period_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (visit && pending_mid) begin
         trigger_ff <= tick_count + period_ff;
      end
   end

endmodule

@@ rtl/core/periodic_timer_bank.sv @@
// top level of the periodic timer bank: controller, cell chain and result stage
//
//  channel | direction | payload                                   | accepted when
//  req_    | in        | tuser: mode; tdata: timer_index           | tvalid && tready
//  rsp_    | out       | tdata: expired_index; tlast: last expiry  | tvalid && tready
//  csr_    | in        | index, 32-bit data, no read-back          | csr_we
//
// a tick walks a token down the NUM_TIMERS cells, one a cycle while the result output
// is not stalled; req_tready is low from the taken tick through launch, the chain, the
// flush step and any expiry still held back.
// a held-back result register lets the final expiry of a tick carry tlast.
// a stalled result output freezes the chain; no request is taken during a tick.
// reset is synchronous and returns the bank to stopped with all flags clear.
module periodic_timer_bank #(
   parameter int NUM_TIMERS = ptb_pkg::NUM_TIMERS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [ptb_pkg::REQ_DATA_W-1:0]   req_tdata,   // [1:0] timer_index
   input  logic [ptb_pkg::REQ_USER_W-1:0]   req_tuser,   // [1:0] mode
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [ptb_pkg::RSP_DATA_W-1:0]   rsp_tdata,   // [1:0] expired_index
   output logic                             rsp_tlast,
   input  logic                             csr_we,
   input  logic [ptb_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [ptb_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import ptb_pkg::*;

   `include "periodic_timer_bank_defines.svh"

   logic                   running_ff;
   logic [TICK_W-1:0]      tick_count_ff;
   logic [COUNT_W-1:0]     timer_count_ff;
   logic [MASK_W-1:0]      one_shot_ff;
   logic                   launch_ff;
   logic                   flush_ff;
   logic                   held_valid_ff;
   logic [INDEX_W-1:0]     held_index_ff;
   logic                   rsp_valid_ff;
   logic [INDEX_W-1:0]     rsp_index_ff;
   logic                   rsp_last_ff;

   ptb_cell_ctrl_type      cell_ctrl [NUM_TIMERS];
   logic [NUM_TIMERS-1:0]  token;
   logic [NUM_TIMERS-1:0]  expired;
   logic                   advance;
   logic                   busy;
   logic                   req_accept;
   ptb_mode_type           mode;
   logic [INDEX_W-1:0]     req_index;
   logic                   any_expired;
   logic [INDEX_W-1:0]     expired_index;
   logic                   scan_done;

   assign mode       = ptb_mode_type'(req_tuser[1:0]);
   assign req_index  = req_tdata[INDEX_W-1:0];
   assign advance    = !rsp_valid_ff || rsp_tready;
   assign busy       = launch_ff || (|token) || flush_ff || held_valid_ff;
   assign req_tready = !busy;
   assign req_accept = req_tvalid && req_tready;
   assign scan_done  = token[NUM_TIMERS-1] && advance;

   assign any_expired = |expired;
   always_comb begin
      expired_index = '0;
      for (int i = 0; i < NUM_TIMERS; i++) begin
         if (expired[i]) begin
            expired_index = INDEX_W'(i);
         end
      end
   end

   genvar g;
   generate
      for (g = 0; g < NUM_TIMERS; g++) begin : gen_cell
         logic token_in;
         if (g == 0) begin : gen_head
            assign token_in = launch_ff;
         end else begin : gen_link
            assign token_in = token[g-1];
         end

         always_comb begin
            cell_ctrl[g].advance   = advance;
            cell_ctrl[g].clear     = req_accept && (mode == MODE_START) && !running_ff;
            cell_ctrl[g].activate  = req_accept && (mode == MODE_ACTIVATE) && running_ff
                                     && (int'(req_index) == g);
            cell_ctrl[g].period_we = csr_we
                                     && (csr_index == CSR_INDEX_W'(int'(CSR_PERIOD_0) + g));
         end

         ptb_cell u_cell (
            .clock        (clock),
            .reset        (reset),
            .ctrl         (cell_ctrl[g]),
            .token_in     (token_in),
            .active       (timer_count_ff > COUNT_W'(g)),
            .one_shot     (one_shot_ff[g]),
            .tick_count   (tick_count_ff),
            .period_wdata (csr_wdata),
            .token_out    (token[g]),
            .expired      (expired[g])
         );
      end
   endgenerate

   // bank control and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff     <= 1'b0;
         tick_count_ff  <= '0;
         timer_count_ff <= '0;
         one_shot_ff    <= '0;
         launch_ff      <= 1'b0;
      end else begin
         if (csr_we && (csr_index == CSR_TIMER_COUNT)) begin
            timer_count_ff <= csr_wdata[COUNT_W-1:0];
         end
         if (csr_we && (csr_index == CSR_ONE_SHOT_MASK)) begin
            one_shot_ff <= csr_wdata[MASK_W-1:0];
         end
         if (launch_ff && advance) begin
            launch_ff <= 1'b0;
         end
         if (req_accept) begin
            case (mode)
               MODE_START: begin
                  running_ff <= 1'b1;
               end
               MODE_STOP: begin
                  running_ff <= 1'b0;
               end
               MODE_TICK: begin
                  if (running_ff) begin
                     tick_count_ff <= tick_count_ff + TICK_W'(1);
                     launch_ff     <= 1'b1;
                  end
               end
               default: begin
               end
            endcase
         end
      end
   end

   // result stage: each expiry is held back until the next one or the flush step, so the final one gets tlast
   always_ff @(posedge clock) begin
      if (reset) begin
         flush_ff      <= 1'b0;
         held_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (advance) begin
            flush_ff <= scan_done;
            if (flush_ff) begin
               if (held_valid_ff) begin
                  rsp_valid_ff  <= 1'b1;
                  held_valid_ff <= 1'b0;
               end
            end else if (any_expired) begin
               held_valid_ff <= 1'b1;
               if (held_valid_ff) begin
                  rsp_valid_ff <= 1'b1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         if (flush_ff) begin
            if (held_valid_ff) begin
               rsp_index_ff <= held_index_ff;
               rsp_last_ff  <= 1'b1;
            end
         end else if (any_expired) begin
            held_index_ff <= expired_index;
            if (held_valid_ff) begin
               rsp_index_ff <= held_index_ff;
               rsp_last_ff  <= 1'b0;
            end
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'(rsp_index_ff);
   assign rsp_tlast  = rsp_last_ff;

   `PTB_ASSERT_NOW(a_single_token, 1'b1, $onehot0({launch_ff, token, flush_ff}),
                   "more than one scan token in the cell chain")
   `PTB_ASSERT_NOW(a_idle_no_held, req_tready, !held_valid_ff,
                   "request taken while an expiry is still held back")
   `PTB_ASSERT_NEXT(a_tick_launch, req_accept && (mode == MODE_TICK) && running_ff,
                    launch_ff, "running tick did not launch a scan")
   `PTB_ASSERT_NOW(a_flush_after_scan, flush_ff, !launch_ff && (token == '0),
                   "flush step overlaps a scan in progress")

endmodule

@@ verif/periodic_timer_bank_checker.sv @@
// checker for the timer bank: tracks requests and register writes, predicts expiries, compares
module periodic_timer_bank_checker #(
   parameter int NUM_TIMERS = ptb_pkg::NUM_TIMERS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   input  logic                             req_tready,
   input  logic [ptb_pkg::REQ_DATA_W-1:0]   req_tdata,   // [1:0] timer_index
   input  logic [ptb_pkg::REQ_USER_W-1:0]   req_tuser,   // [1:0] mode
   input  logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   input  logic [ptb_pkg::RSP_DATA_W-1:0]   rsp_tdata,   // [1:0] expired_index
   input  logic                             rsp_tlast,
   input  logic                             csr_we,
   input  logic [ptb_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [ptb_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output int unsigned                      mismatch_count,
   output int unsigned                      expiries_waiting,
   output int unsigned                      expiries_checked
);
   timeunit 1ns;
   timeprecision 1ps;
   import ptb_pkg::*;

   typedef struct packed {
      logic [INDEX_W-1:0] timer;
      logic               last;
   } expiry_type;

   // register copies
   logic [COUNT_W-1:0] visit_count;
   logic [MASK_W-1:0]  one_shot;
   logic [TICK_W-1:0]  period [MAX_TIMERS];

   // bank state
   logic               bank_running;
   logic [TICK_W-1:0]  tick_now;
   logic [MAX_TIMERS-1:0] pending;
   logic [MAX_TIMERS-1:0] armed;
   logic [TICK_W-1:0]  trigger_at [MAX_TIMERS];

   expiry_type due_expiries [$];
   expiry_type head;

   initial begin
      mismatch_count   = 0;
      expiries_waiting = 0;
      expiries_checked = 0;
   end

   task automatic apply_request(input ptb_mode_type mode, input logic [INDEX_W-1:0] idx);
      logic [INDEX_W-1:0] fired [$];
      int unsigned span;
      case (mode)
         MODE_START: begin
            if (!bank_running) begin
               pending      = '0;
               armed        = '0;
               bank_running = 1'b1;
            end
         end
         MODE_STOP: begin
            bank_running = 1'b0;
         end
         MODE_ACTIVATE: begin
            if (bank_running && int'(idx) < NUM_TIMERS) pending[idx] = 1'b1;
         end
         default: begin
            if (bank_running) begin
               tick_now = tick_now + TICK_W'(1);
               span = (int'(visit_count) > NUM_TIMERS) ? NUM_TIMERS : int'(visit_count);
               for (int t = 0; t < span; t++) begin
                  // plain unsigned compare, so a wrapped trigger fires early
                  if (armed[t] && tick_now >= trigger_at[t]) begin
                     armed[t]   = 1'b0;
                     pending[t] = !one_shot[t];
                     fired.push_back(t[INDEX_W-1:0]);
                  end
                  if (pending[t]) begin
                     armed[t]      = 1'b1;
                     pending[t]    = 1'b0;
                     trigger_at[t] = tick_now + period[t];
                  end
               end
               for (int k = 0; k < fired.size(); k++)
                  due_expiries.push_back('{timer: fired[k], last: (k == fired.size() - 1)});
            end
         end
      endcase
   endtask

   always @(posedge clock) begin
      if (reset) begin
         visit_count  = '0;
         one_shot     = '0;
         bank_running = 1'b0;
         tick_now     = '0;
         pending      = '0;
         armed        = '0;
         for (int t = 0; t < MAX_TIMERS; t++) begin
            period[t]     = '0;
            trigger_at[t] = '0;
         end
         due_expiries.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_TIMER_COUNT:   visit_count = csr_wdata[COUNT_W-1:0];
               CSR_ONE_SHOT_MASK: one_shot    = csr_wdata[MASK_W-1:0];
               CSR_PERIOD_0:      period[0]   = csr_wdata;
               CSR_PERIOD_1:      period[1]   = csr_wdata;
               CSR_PERIOD_2:      period[2]   = csr_wdata;
               CSR_PERIOD_3:      period[3]   = csr_wdata;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready)
            apply_request(ptb_mode_type'(req_tuser), req_tdata[INDEX_W-1:0]);
         if (rsp_tvalid && rsp_tready) begin
            if (due_expiries.size() == 0) begin
               $error("unexpected expiry: expired_index %0d, last %0d",
                      rsp_tdata[INDEX_W-1:0], rsp_tlast);
               mismatch_count++;
            end else begin
               head = due_expiries.pop_front();
               expiries_checked++;
               if (rsp_tdata[INDEX_W-1:0] !== head.timer) begin
                  $error("expired_index: expected %0d, actual %0d",
                         head.timer, rsp_tdata[INDEX_W-1:0]);
                  mismatch_count++;
               end
               if (rsp_tlast !== head.last) begin
                  $error("last: expected %0d, actual %0d", head.last, rsp_tlast);
                  mismatch_count++;
               end
            end
         end
      end
      expiries_waiting = due_expiries.size();
   end

endmodule

@@ verif/periodic_timer_bank_tb.sv @@
// testbench top for the timer bank: clock, reset, request and register stimulus, verdict
module periodic_timer_bank_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import ptb_pkg::*;

   localparam int NUM_TIMERS    = 4;
   localparam int TICK_SPAN     = NUM_TIMERS + 2;
   localparam int SETTLE_CYCLES = 4 * TICK_SPAN;
   localparam int HOLD_CYCLES   = 300;
   localparam int STALL_LIMIT   = 5000;
   localparam int PHASE_ITEMS   = 29;
   // indexes past the register list
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_A = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_B = 3'd7;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [REQ_DATA_W-1:0]   req_tdata = '0;   // [1:0] timer_index
   logic [REQ_USER_W-1:0]   req_tuser = '0;   // [1:0] mode
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]   rsp_tdata;        // [1:0] expired_index
   logic                    rsp_tlast;
   logic                    csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0]   csr_wdata = '0;

   int unsigned mismatch_count;
   int unsigned expiries_waiting;
   int unsigned expiries_checked;

   int unsigned requests_sent = 0;
   int unsigned settings_applied = 0;
   int unsigned idle_cycles = 0;
   bit          bank_on = 1'b0;
   bit          hold_due = 1'b0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   periodic_timer_bank #(.NUM_TIMERS(NUM_TIMERS)) u_top (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   periodic_timer_bank_checker #(.NUM_TIMERS(NUM_TIMERS)) u_checker (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .mismatch_count(mismatch_count),
      .expiries_waiting(expiries_waiting),
      .expiries_checked(expiries_checked)
   );

   // watchdog: cycles with no request, result or register write taken
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("periodic_timer_bank_tb: done, errors");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // result side: stretches of different stall styles, and one long hold-off
   initial begin : rsp_stall_pattern
      int unsigned style;
      int unsigned span;
      bit          held;
      held = 1'b0;
      forever begin
         style = $urandom_range(0, 3);
         span  = $urandom_range(8, 60);
         repeat (span) begin
            @(posedge clock);
            if (hold_due && !held) begin
               rsp_tready <= 1'b0;
               repeat (HOLD_CYCLES) @(posedge clock);
               held = 1'b1;
            end
            case (style)
               0:       rsp_tready <= 1'b1;
               1:       rsp_tready <= 1'($urandom_range(0, 1));
               2:       rsp_tready <= ($urandom_range(0, 3) == 0);
               default: rsp_tready <= ($urandom_range(0, 7) != 0);
            endcase
         end
      end
   end

   task automatic send_request(input ptb_mode_type mode, input logic [INDEX_W-1:0] idx);
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= {{(REQ_DATA_W-INDEX_W){1'b0}}, idx};
      do @(posedge clock); while (!req_tready);
      case (mode)
         MODE_START:    begin if (!bank_on) requests_sent++; bank_on = 1'b1; end
         MODE_STOP:     begin if (bank_on) requests_sent++; bank_on = 1'b0; end
         default:       if (bank_on) requests_sent++;
      endcase
   endtask

   task automatic pause_sender(input int unsigned cycles);
      if (cycles > 0) begin
         req_tvalid <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   // drain every expected expiry, then give a tick with no expiry time to finish
   task automatic settle_bank();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (expiries_waiting != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   task automatic apply_settings(input logic [COUNT_W-1:0] count, input logic [MASK_W-1:0] mask,
                                 input logic [TICK_W-1:0] p0, input logic [TICK_W-1:0] p1,
                                 input logic [TICK_W-1:0] p2, input logic [TICK_W-1:0] p3);
      write_csr(CSR_TIMER_COUNT, CSR_DATA_W'(count));
      write_csr(CSR_ONE_SHOT_MASK, CSR_DATA_W'(mask));
      write_csr(CSR_PERIOD_0, p0);
      write_csr(CSR_PERIOD_1, p1);
      write_csr(CSR_PERIOD_2, p2);
      write_csr(CSR_PERIOD_3, p3);
      // writes past the list must leave everything alone
      write_csr($urandom_range(0, 1) ? CSR_SPARE_A : CSR_SPARE_B, $urandom());
      csr_we <= 1'b0;
      settings_applied++;
   endtask

   // mostly short periods so expiries are frequent, now and then the extremes
   function automatic logic [TICK_W-1:0] pick_period();
      case ($urandom_range(0, 9))
         0:       return 32'hFFFF_FFFF;
         1:       return 32'hFFFF_FFFE;
         2:       return 32'h8000_0000;
         3:       return $urandom();
         default: return $urandom_range(0, 6);
      endcase
   endfunction

   task automatic send_random_request();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (!bank_on) begin
         if (pick < 80)      send_request(MODE_START, INDEX_W'($urandom_range(0, 3)));
         else if (pick < 88) send_request(MODE_TICK, INDEX_W'($urandom_range(0, 3)));
         else if (pick < 94) send_request(MODE_ACTIVATE, INDEX_W'($urandom_range(0, 3)));
         else                send_request(MODE_STOP, INDEX_W'($urandom_range(0, 3)));
      end else begin
         if (pick < 55)      send_request(MODE_TICK, INDEX_W'($urandom_range(0, 3)));
         else if (pick < 90) send_request(MODE_ACTIVATE, INDEX_W'($urandom_range(0, 3)));
         else if (pick < 96) send_request(MODE_STOP, INDEX_W'($urandom_range(0, 3)));
         else                send_request(MODE_START, INDEX_W'($urandom_range(0, 3)));
      end
   endtask

   task automatic run_phase(input int unsigned n_items);
      int unsigned target;
      int unsigned burst;
      target = requests_sent + n_items;
      while (requests_sent < target) begin
         burst = $urandom_range(1, 12);
         repeat (burst) send_random_request();
         // some bursts run straight into the next one
         if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(1, 6));
      end
   endtask

   initial begin : stimulus
      logic [COUNT_W-1:0] count;
      logic [MASK_W-1:0]  mask;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: ignored modes while stopped, start/stop, wrapped and zero periods
      apply_settings(3'd4, 4'b0101, 32'd0, 32'd1, 32'hFFFF_FFFF, 32'h8000_0000);
      send_request(MODE_TICK, 2'd0);
      send_request(MODE_ACTIVATE, 2'd1);
      send_request(MODE_STOP, 2'd0);
      send_request(MODE_START, 2'd0);
      send_request(MODE_START, 2'd3);
      send_request(MODE_ACTIVATE, 2'd0);
      send_request(MODE_ACTIVATE, 2'd1);
      send_request(MODE_ACTIVATE, 2'd2);
      send_request(MODE_ACTIVATE, 2'd3);
      repeat (4) send_request(MODE_TICK, 2'd3);
      send_request(MODE_STOP, 2'd0);
      send_request(MODE_TICK, 2'd0);
      send_request(MODE_ACTIVATE, 2'd3);
      send_request(MODE_START, 2'd0);
      send_request(MODE_ACTIVATE, 2'd0);
      repeat (3) send_request(MODE_TICK, 2'd0);
      send_request(MODE_ACTIVATE, 2'd3);
      send_request(MODE_TICK, 2'd0);
      settle_bank();

      for (int phase = 0; phase < 8; phase++) begin
         count = COUNT_W'($urandom_range(0, 4));
         mask  = MASK_W'($urandom_range(0, 15));
         case (phase)
            0: apply_settings(3'd4, 4'h0, 32'd0, 32'd1, 32'd2, 32'd3);
            1: apply_settings(3'd4, 4'hF, pick_period(), pick_period(), pick_period(),
                              pick_period());
            2: apply_settings(3'd7, mask, pick_period(), pick_period(), pick_period(),
                              pick_period());
            3: apply_settings(3'd0, mask, 32'd0, 32'd0, 32'd0, 32'd0);
            4: apply_settings(3'd1, mask, pick_period(), pick_period(), pick_period(),
                              pick_period());
            5: apply_settings(3'd2, mask, 32'd1, 32'd0, 32'd2, 32'd0);
            6: apply_settings(3'd3, 4'b1010, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFE,
                              pick_period());
            default: apply_settings(count, mask, pick_period(), pick_period(), pick_period(),
                                    pick_period());
         endcase
         // the long result hold-off lands in the first phase, where all four timers are periodic
         if (phase == 0) hold_due = 1'b1;
         run_phase(PHASE_ITEMS);
         settle_bank();
      end

      $display("covered %0d effective requests over %0d register settings,",
               requests_sent, settings_applied);
      $display("  %0d expiries compared against the prediction", expiries_checked);
      if (mismatch_count == 0 && expiries_waiting == 0) begin
         $display("periodic_timer_bank_tb: done, clean");
      end else begin
         $display("periodic_timer_bank_tb: done, errors");
      end
      $finish;
   end

endmodule

@@ sim.f @@
+incdir+rtl/core
rtl/core/ptb_pkg.sv
rtl/core/ptb_cell.sv
rtl/core/periodic_timer_bank.sv
verif/periodic_timer_bank_checker.sv
verif/periodic_timer_bank_tb.sv
